// ===== hdl/tcsa_pkg.sv =====
`default_nettype none

package tcsa_pkg;

  localparam int WORD_BITS = 64;
  localparam int POS_W     = 6;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_RESIZE = 2'd1,
    OP_FREE   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OOM       = 2'd1;
  localparam logic [1:0] STAT_TOO_LARGE = 2'd2;

  localparam logic POOL_SMALL = 1'b0;
  localparam logic POOL_BIG   = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_MODIFY,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } find_res_t;

endpackage

`default_nettype wire

// ===== hdl/tcsa_find.sv =====
`default_nettype none

module tcsa_find (
  input  logic [tcsa_pkg::WORD_BITS-1:0] word,
  output tcsa_pkg::find_res_t            res
);
  import tcsa_pkg::*;

  always_comb begin
    res = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.found = 1'b1;
        res.pos   = POS_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tcsa_occ_mem.sv =====
`default_nettype none

module tcsa_occ_mem #(
  parameter int DEPTH = 33,
  parameter int AW    = 6
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [tcsa_pkg::WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]                  raddr,
  output logic [tcsa_pkg::WORD_BITS-1:0] rdata
);
  import tcsa_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/tcsa_size_mem.sv =====
`default_nettype none

module tcsa_size_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/two_class_slot_allocator_core.sv =====
// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------------------------
// command   | start, busy           | op, request_size, handle_pool, handle_slot
// result    | done (one-cycle pulse)| status, result_pool, result_slot, moved,
//           |                       | copy_length
//
// A command transfer completes on an edge with start high and busy low.
// Out-of-range handles, too-large requests and the unused code: done is registered from the
// dispatch state; free and resize in place: from the modify state, after dispatch.
// Allocation: dispatch, then the occupancy word scan of the chosen pool, one 64-bit word
// per cycle from the occupancy memory, until a word with a free slot or the pool's last
// word; a small-to-big move passes through the modify state before scanning the big pool.
// After reset a clearing pass of SMALL_SLOTS/64 + BIG_SLOTS/64 words, rounded up per pool,
// holds busy high. Results are never stalled.
`default_nettype none

module two_class_slot_allocator_core #(
  parameter int SMALL_SLOTS      = 2048,
  parameter int BIG_SLOTS        = 63,
  parameter int SMALL_SLOT_BYTES = 512,
  parameter int BIG_SLOT_BYTES   = 1048576,
  parameter int HEADER_BYTES     = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [23:0] request_size,
  input  logic        handle_pool,
  input  logic [10:0] handle_slot,
  output logic        done,
  output logic [1:0]  status,
  output logic        result_pool,
  output logic [10:0] result_slot,
  output logic        moved,
  output logic [8:0]  copy_length
);
  import tcsa_pkg::*;

  localparam int SMALL_WORDS = (SMALL_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int BIG_WORDS   = (BIG_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int OCC_DEPTH   = SMALL_WORDS + BIG_WORDS;
  localparam int OCC_AW      = $clog2(OCC_DEPTH);
  localparam int SCAN_W      = OCC_AW + 1;
  localparam int SIZE_AW     = $clog2(SMALL_SLOTS);
  localparam int SIZE_DW     = $clog2(SMALL_SLOT_BYTES);
  localparam int SMALL_TAIL  = SMALL_SLOTS % WORD_BITS;
  localparam int BIG_TAIL    = BIG_SLOTS % WORD_BITS;
  localparam logic [WORD_BITS-1:0] ONE_W = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] ALL_W = ~(WORD_BITS'(0));
  localparam logic [WORD_BITS-1:0] SMALL_TAIL_MASK =
    (SMALL_TAIL == 0) ? ALL_W : ((ONE_W << SMALL_TAIL) - ONE_W);
  localparam logic [WORD_BITS-1:0] BIG_TAIL_MASK =
    (BIG_TAIL == 0) ? ALL_W : ((ONE_W << BIG_TAIL) - ONE_W);

  state_t              state, state_next;
  op_t                 cur_op;
  logic [23:0]         cur_size;
  logic                cur_pool;
  logic [10:0]         cur_slot;
  logic [SCAN_W-1:0]   scan_addr, scan_addr_next;
  logic                chk_valid, chk_valid_next;
  logic [OCC_AW-1:0]   chk_addr, chk_addr_next;
  logic                scan_pool, scan_pool_next;
  logic [8:0]          copy_len, copy_len_next;
  logic [OCC_AW-1:0]   clr_cnt, clr_cnt_next;
  logic                done_next;
  logic [1:0]          status_next;
  logic                result_pool_next;
  logic [10:0]         result_slot_next;
  logic                moved_next;
  logic [8:0]          copy_length_next;

  logic                fin;
  logic [1:0]          fin_status;
  logic                fin_pool;
  logic [10:0]         fin_slot;
  logic                fin_moved;
  logic [8:0]          fin_copy;

  logic                occ_we;
  logic [OCC_AW-1:0]   occ_waddr, occ_raddr;
  logic [WORD_BITS-1:0] occ_wdata, occ_rdata;
  logic                size_we;
  logic [SIZE_AW-1:0]  size_waddr, size_raddr;
  logic [SIZE_DW-1:0]  size_wdata, size_rdata;

  logic [25:0]         size_hdr;
  logic                fits_small, fits_big, in_range, size_nz;
  logic [31:0]         handle32, slot32, base32, scan_words;
  logic [31:0]         scan_raddr32, chk_waddr32, found32, copy32;
  logic [OCC_AW-1:0]   handle_addr;
  logic [POS_W-1:0]    handle_pos;
  logic                old_bit, new_bit, is_last;
  logic [WORD_BITS-1:0] mod_word, masked_word;
  find_res_t           fr;

  tcsa_occ_mem #(.DEPTH(OCC_DEPTH), .AW(OCC_AW)) u_occ (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  tcsa_size_mem #(.DEPTH(SMALL_SLOTS), .AW(SIZE_AW), .DW(SIZE_DW)) u_size (
    .clk   (clk),
    .we    (size_we),
    .waddr (size_waddr),
    .wdata (size_wdata),
    .raddr (size_raddr),
    .rdata (size_rdata)
  );

  tcsa_find u_find (
    .word (masked_word),
    .res  (fr)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    size_hdr     = {2'b00, cur_size} + 26'(HEADER_BYTES);
    fits_small   = size_hdr < 26'(SMALL_SLOT_BYTES);
    fits_big     = size_hdr < 26'(BIG_SLOT_BYTES);
    size_nz      = (cur_size != 24'd0);
    slot32       = 32'(cur_slot);
    in_range     = cur_pool ? (slot32 < 32'(BIG_SLOTS)) : (slot32 < 32'(SMALL_SLOTS));
    handle32     = (cur_pool ? 32'(SMALL_WORDS) : 32'd0) + (slot32 >> POS_W);
    handle_addr  = handle32[OCC_AW-1:0];
    handle_pos   = cur_slot[POS_W-1:0];
    old_bit      = occ_rdata[handle_pos];
    new_bit      = (cur_op == OP_RESIZE) && size_nz;
    mod_word     = (occ_rdata & ~(ONE_W << handle_pos)) |
                   (WORD_BITS'(new_bit) << handle_pos);
    base32       = scan_pool ? 32'(SMALL_WORDS) : 32'd0;
    scan_words   = scan_pool ? 32'(BIG_WORDS) : 32'(SMALL_WORDS);
    scan_raddr32 = base32 + 32'(scan_addr);
    chk_waddr32  = base32 + 32'(chk_addr);
    is_last      = (32'(chk_addr) == scan_words - 32'd1);
    masked_word  = occ_rdata |
                   ~(is_last ? (scan_pool ? BIG_TAIL_MASK : SMALL_TAIL_MASK) : ALL_W);
    found32      = (32'(chk_addr) << POS_W) | 32'(fr.pos);
    copy32       = 32'(size_rdata);
  end

  always_comb begin
    state_next       = state;
    scan_addr_next   = scan_addr;
    chk_valid_next   = 1'b0;
    chk_addr_next    = chk_addr;
    scan_pool_next   = scan_pool;
    copy_len_next    = copy_len;
    clr_cnt_next     = clr_cnt;
    done_next        = 1'b0;
    status_next      = status;
    result_pool_next = result_pool;
    result_slot_next = result_slot;
    moved_next       = moved;
    copy_length_next = copy_length;
    fin              = 1'b0;
    fin_status       = STAT_OK;
    fin_pool         = POOL_SMALL;
    fin_slot         = '0;
    fin_moved        = 1'b0;
    fin_copy         = '0;
    occ_we           = 1'b0;
    occ_waddr        = handle_addr;
    occ_wdata        = mod_word;
    occ_raddr        = handle_addr;
    size_we          = 1'b0;
    size_waddr       = slot32[SIZE_AW-1:0];
    size_wdata       = cur_size[SIZE_DW-1:0];
    size_raddr       = slot32[SIZE_AW-1:0];

    unique case (state)
      S_CLEAR: begin
        occ_we       = 1'b1;
        occ_waddr    = clr_cnt;
        occ_wdata    = '0;
        clr_cnt_next = clr_cnt + 1'b1;
        if (32'(clr_cnt) == 32'(OCC_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (cur_op) inside
          OP_ALLOC: begin
            if (fits_small || fits_big) begin
              state_next     = S_SCAN;
              scan_pool_next = fits_small ? POOL_SMALL : POOL_BIG;
              scan_addr_next = '0;
            end else begin
              fin        = 1'b1;
              fin_status = STAT_TOO_LARGE;
              fin_pool   = POOL_BIG;
            end
          end
          OP_RESIZE, OP_FREE: begin
            if (!in_range) begin
              fin      = 1'b1;
              fin_pool = cur_pool;
              fin_slot = cur_slot;
            end else if (cur_op == OP_RESIZE && !fits_big &&
                         !(cur_pool == POOL_SMALL && fits_small)) begin
              fin        = 1'b1;
              fin_status = STAT_TOO_LARGE;
              fin_pool   = POOL_BIG;
              fin_slot   = (cur_pool == POOL_BIG) ? cur_slot : 11'd0;
            end else begin
              state_next = S_MODIFY;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_MODIFY: begin
        if (cur_op == OP_RESIZE && cur_pool == POOL_SMALL && !fits_small) begin
          copy_len_next  = old_bit ? copy32[8:0] : 9'd0;
          state_next     = S_SCAN;
          scan_pool_next = POOL_BIG;
          scan_addr_next = '0;
        end else begin
          occ_we   = 1'b1;
          size_we  = (cur_op == OP_RESIZE) && (cur_pool == POOL_SMALL);
          fin      = 1'b1;
          fin_pool = cur_pool;
          fin_slot = cur_slot;
        end
      end
      S_SCAN: begin
        occ_raddr = scan_raddr32[OCC_AW-1:0];
        if (32'(scan_addr) < scan_words) begin
          chk_valid_next = 1'b1;
          chk_addr_next  = scan_addr[OCC_AW-1:0];
          scan_addr_next = scan_addr + 1'b1;
        end
        if (chk_valid) begin
          if (fr.found) begin
            occ_we     = 1'b1;
            occ_waddr  = chk_waddr32[OCC_AW-1:0];
            occ_wdata  = occ_rdata | (WORD_BITS'(size_nz) << fr.pos);
            size_we    = (scan_pool == POOL_SMALL);
            size_waddr = found32[SIZE_AW-1:0];
            fin        = 1'b1;
            fin_pool   = scan_pool;
            fin_slot   = found32[10:0];
            fin_moved  = (cur_op == OP_RESIZE);
            fin_copy   = (cur_op == OP_RESIZE) ? copy_len : 9'd0;
          end else if (is_last) begin
            fin        = 1'b1;
            fin_status = STAT_OOM;
            fin_pool   = scan_pool;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next       = S_IDLE;
      done_next        = 1'b1;
      status_next      = fin_status;
      result_pool_next = fin_pool;
      result_slot_next = fin_slot;
      moved_next       = fin_moved;
      copy_length_next = fin_copy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      chk_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      chk_valid <= chk_valid_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cur_op   <= op_t'(op);
      cur_size <= request_size;
      cur_pool <= handle_pool;
      cur_slot <= handle_slot;
    end
    scan_addr   <= scan_addr_next;
    chk_addr    <= chk_addr_next;
    scan_pool   <= scan_pool_next;
    copy_len    <= copy_len_next;
    status      <= status_next;
    result_pool <= result_pool_next;
    result_slot <= result_slot_next;
    moved       <= moved_next;
    copy_length <= copy_length_next;
  end

`ifndef ASSERT_OFF
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer taken without going busy");
  a_clear_busy: assert property (@(posedge clk) disable iff (rst) $fell(rst) |-> busy)
    else $error("not busy during clearing pass");
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst) !busy |-> !occ_we)
    else $error("occupancy write while idle");
  a_move_big: assert property (@(posedge clk) disable iff (rst)
    (done && moved) |-> (result_pool == POOL_BIG && status == STAT_OK))
    else $error("move reported without a big slot");
`endif

endmodule

`default_nettype wire
